>>> sv/mfsf_pkg.sv
// ----------------------------------------------------------------------------
// mfsf_pkg
// Shared types and constants for the market feed sequence filter.
// ----------------------------------------------------------------------------
package mfsf_pkg;

  // The subscription mask has a fixed number of bits; types above it are
  // never subscribed.
  localparam int MASK_BITS = 4;
  localparam int TYPE_W    = 8;
  localparam int SRC_W     = 32;
  localparam int SEQ_W     = 32;
  localparam int STATUS_W  = 64;
  localparam int VERDICT_W = 3;

  localparam logic KIND_SNAPSHOT = 1'b0;
  localparam logic KIND_STATUS   = 1'b1;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_OK             = 3'd0,
    VERDICT_INVALID        = 3'd1,
    VERDICT_UNSUBSCRIBED   = 3'd2,
    VERDICT_STALE          = 3'd3,
    VERDICT_SOURCE_CHANGED = 3'd4,
    VERDICT_STATUS_SAME    = 3'd5
  } verdict_t;

  // Outcome of one word: verdict plus the state updates it commits.
  typedef struct packed {
    logic     seq_we;
    logic     status_we;
    logic     src_we;
    verdict_t verdict;
  } decision_t;

endpackage

>>> sv/market_feed_sequence_filter.sv
// ----------------------------------------------------------------------------
// market_feed_sequence_filter
// Per-market-type snapshot sequence and status change filter.
// ----------------------------------------------------------------------------
// Takes one word per cycle while in_stall is low and returns one verdict per
// word through the stage 1 and output registers. On acceptance the per-type
// sequence and status tables (synchronous RAMs) are read; stage 1 compares
// and writes back. A word to the same type right behind another is served by
// forwarding inside the tables, so there is no bubble. Tables start cleared
// through per-entry valid bits, so there is no clearing pass after reset.
// Write subscribed_mask only while no word is in flight.
// ----------------------------------------------------------------------------
module market_feed_sequence_filter #(
  parameter int MARKET_TYPES = 4,
  parameter int STATUS_BYTES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [mfsf_pkg::MASK_BITS-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic [mfsf_pkg::TYPE_W-1:0]   market_type,
  input  logic [mfsf_pkg::SRC_W-1:0]    source_id,
  input  logic [mfsf_pkg::SEQ_W-1:0]    sequence_number,
  input  logic [mfsf_pkg::STATUS_W-1:0] session_status,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mfsf_pkg::VERDICT_W-1:0] verdict
);

  import mfsf_pkg::*;

  localparam int SW     = 8 * STATUS_BYTES;
  localparam int SLOT_W = (MARKET_TYPES > 1) ? $clog2(MARKET_TYPES) : 1;

  logic [MASK_BITS-1:0] subscribed_mask;
  logic [SRC_W-1:0]     current_source;

  // stage 1 word
  logic                 s1_valid;
  logic                 s1_valid_next;
  logic                 s1_kind;
  logic                 s1_type_ok;
  logic                 s1_subscribed;
  logic [SLOT_W-1:0]    s1_slot;
  logic [SRC_W-1:0]     s1_source;
  logic [SEQ_W-1:0]     s1_seq;
  logic [SW-1:0]        s1_status;

  logic                 out_open;
  logic                 s1_adv;
  logic                 in_acc;
  logic                 type_ok;
  logic                 subscribed;
  logic [1:0]           mask_idx;
  logic [SLOT_W-1:0]    rd_slot;
  logic [SEQ_W-1:0]     last_sequence;
  logic [SW-1:0]        last_status;
  decision_t            decision;
  verdict_t             out_verdict;

  assign out_open = !out_valid || !out_stall;
  assign s1_adv   = s1_valid && out_open;
  assign in_stall = s1_valid && !out_open;
  assign in_acc   = in_valid && !in_stall;

  assign type_ok  = (market_type != '0) && (market_type <= TYPE_W'(MARKET_TYPES));
  assign mask_idx = market_type[1:0] - 2'd1;
  assign subscribed = (market_type != '0) && (market_type <= TYPE_W'(MASK_BITS))
                      && subscribed_mask[mask_idx];
  assign rd_slot  = type_ok ? SLOT_W'(market_type - TYPE_W'(1)) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      subscribed_mask <= '0;
    end else if (cfg_write) begin
      subscribed_mask <= cfg_data;
    end
  end

  always_comb begin
    s1_valid_next = s1_valid;
    priority if (in_acc) begin
      s1_valid_next = 1'b1;
    end else if (s1_adv) begin
      s1_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind       <= kind;
      s1_type_ok    <= type_ok;
      s1_subscribed <= subscribed;
      s1_slot       <= rd_slot;
      s1_source     <= source_id;
      s1_seq        <= sequence_number;
      s1_status     <= session_status[SW-1:0];
    end
  end

  mfsf_state_ram #(
    .DEPTH (MARKET_TYPES),
    .WIDTH (SEQ_W)
  ) u_seq_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_acc),
    .rd_addr (rd_slot),
    .wr_en   (s1_adv && decision.seq_we),
    .wr_addr (s1_slot),
    .wr_data (s1_seq),
    .rd_data (last_sequence)
  );

  mfsf_state_ram #(
    .DEPTH (MARKET_TYPES),
    .WIDTH (SW)
  ) u_status_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_acc),
    .rd_addr (rd_slot),
    .wr_en   (s1_adv && decision.status_we),
    .wr_addr (s1_slot),
    .wr_data (s1_status),
    .rd_data (last_status)
  );

  mfsf_verdict_unit #(
    .SW (SW)
  ) u_verdict (
    .kind            (s1_kind),
    .type_ok         (s1_type_ok),
    .subscribed      (s1_subscribed),
    .source_id       (s1_source),
    .sequence_number (s1_seq),
    .session_status  (s1_status),
    .current_source  (current_source),
    .last_sequence   (last_sequence),
    .last_status     (last_status),
    .decision        (decision)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      current_source <= '0;
    end else if (s1_adv && decision.src_we) begin
      current_source <= s1_source;
    end
  end

  // Output register: load on advance, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_verdict <= decision.verdict;
    end
  end

  assign verdict = out_verdict;

endmodule

>>> sv/mfsf_state_ram.sv
// ----------------------------------------------------------------------------
// mfsf_state_ram
// Per-type state table: synchronous RAM, registered read, entry valid bits
// that reset clears, and write-to-read forwarding for back-to-back access.
// ----------------------------------------------------------------------------
module mfsf_state_ram #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 32,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] entry_valid;
  logic [WIDTH-1:0] rd_q;
  logic             rd_valid_q;
  logic             fwd_q;
  logic [WIDTH-1:0] fwd_data_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (wr_en) begin
      entry_valid[wr_addr] <= 1'b1;
    end
  end

  // Capture read data; a write to the same entry at the same edge wins.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q       <= mem[rd_addr];
      rd_valid_q <= entry_valid[rd_addr];
      fwd_q      <= wr_en && (wr_addr == rd_addr);
      fwd_data_q <= wr_data;
    end
  end

  always_comb begin
    if (fwd_q) begin
      rd_data = fwd_data_q;
    end else if (rd_valid_q) begin
      rd_data = rd_q;
    end else begin
      rd_data = '0;
    end
  end

endmodule

>>> sv/mfsf_verdict_unit.sv
// ----------------------------------------------------------------------------
// mfsf_verdict_unit
// Compares one word against the stored state of its market type and decides
// the verdict and which state entries to update.
// ----------------------------------------------------------------------------
module mfsf_verdict_unit #(
  parameter int SW = 64
) (
  input  logic                     kind,
  input  logic                     type_ok,
  input  logic                     subscribed,
  input  logic [mfsf_pkg::SRC_W-1:0] source_id,
  input  logic [mfsf_pkg::SEQ_W-1:0] sequence_number,
  input  logic [SW-1:0]            session_status,
  input  logic [mfsf_pkg::SRC_W-1:0] current_source,
  input  logic [mfsf_pkg::SEQ_W-1:0] last_sequence,
  input  logic [SW-1:0]            last_status,
  output mfsf_pkg::decision_t      decision
);

  import mfsf_pkg::*;

  always_comb begin
    decision = '{seq_we: 1'b0, status_we: 1'b0, src_we: 1'b0, verdict: VERDICT_OK};
    priority if (!type_ok) begin
      decision.verdict = VERDICT_INVALID;
    end else if (!subscribed) begin
      decision.verdict = VERDICT_UNSUBSCRIBED;
    end else if (kind == KIND_SNAPSHOT) begin
      if (source_id == current_source) begin
        if (sequence_number > last_sequence) begin
          decision.seq_we = 1'b1;
        end else begin
          decision.verdict = VERDICT_STALE;
        end
      end else begin
        // adopt the new source and reload the sequence
        decision.src_we = 1'b1;
        decision.seq_we = 1'b1;
        if (current_source != '0) begin
          decision.verdict = VERDICT_SOURCE_CHANGED;
        end
      end
    end else begin
      if (session_status == last_status) begin
        decision.verdict = VERDICT_STATUS_SAME;
      end else begin
        decision.status_we = 1'b1;
      end
    end
  end

endmodule

>>> sv/mfsf_checker.sv
// ----------------------------------------------------------------------------
// mfsf_checker
// Port-level checks for the market feed sequence filter, bound to the top.
// ----------------------------------------------------------------------------
module mfsf_checker #(
  parameter int MARKET_TYPES = 4
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic [mfsf_pkg::TYPE_W-1:0]    market_type,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [mfsf_pkg::VERDICT_W-1:0] verdict
);

  import mfsf_pkg::*;

  // A held verdict does not change while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(verdict))
    else $error("verdict word changed while stalled");

  a_verdict_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (verdict <= VERDICT_W'(VERDICT_STATUS_SAME)))
    else $error("verdict code out of range");

  // Input only backs up when the output word is stuck.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free output");

  // An accepted word of invalid type comes out flagged once the output is not stalled.
  a_invalid_type: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall &&
     ((market_type == '0) || (market_type > TYPE_W'(MARKET_TYPES))))
    ##1 !out_stall |=> out_valid && (verdict == VERDICT_W'(VERDICT_INVALID)))
    else $error("invalid type not flagged");

endmodule

bind market_feed_sequence_filter mfsf_checker #(
  .MARKET_TYPES (MARKET_TYPES)
) u_mfsf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .market_type (market_type),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .verdict     (verdict)
);
